>>> sv/etbg_pkg.sv
package etbg_pkg;

    localparam int DEF_SINE_TABLE_DEPTH = 1024;
    localparam int DEF_SAMPLE_WIDTH     = 16;
    localparam int DEF_LENGTH_WIDTH     = 20;

    localparam int SINE_W  = 15;
    localparam int GAIN_W  = 16;
    localparam int PHASE_W = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [SINE_W-1:0] FULL_Q15 = 15'h7FFF;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_LENGTH  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENVELOPE_STEP = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN          = 8'd3;

    typedef struct packed {
        logic              neg;
        logic [SINE_W-1:0] mag;
    } t_sine_look;

    // q30 taylor series of sin(x), scaled to q15 with rounding
    function automatic logic [SINE_W-1:0] sine_entry(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [64:0] sum;
        logic [63:0]        prod;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed({1'b0, x});
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed({1'b0, term});
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed({1'b0, term});
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed({1'b0, term});
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed({1'b0, term});
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed({1'b0, term});
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed({1'b0, term});
        if (sum < 0) begin
            sum = '0;
        end
        prod = sum[63:0] * 64'd32767 + 64'd536870912;
        return prod[44:30];
    endfunction

endpackage

>>> sv/etbg_sine_lookup.sv
module etbg_sine_lookup #(
    parameter int SINE_TABLE_DEPTH = etbg_pkg::DEF_SINE_TABLE_DEPTH
) (
    input  logic                  i_clk,
    input  logic [31:0]           i_phase,
    output etbg_pkg::t_sine_look  o_look
);
    import etbg_pkg::*;

    localparam int IW = $clog2(SINE_TABLE_DEPTH);
    localparam int PW = 30 + IW + 1;
    localparam logic [IW:0] DEPTH_W = (IW + 1)'(SINE_TABLE_DEPTH);
    localparam logic [IW-1:0] TOP_IDX = IW'(SINE_TABLE_DEPTH - 1);

    logic [SINE_W-1:0] w_rom [SINE_TABLE_DEPTH];

    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
        localparam logic [63:0] X =
            (64'(2 * k + 1) * PI_Q30) / 64'(4 * SINE_TABLE_DEPTH);
        assign w_rom[k] = sine_entry(X);
    end

    logic [PW-1:0]   w_prod;
    logic [IW:0]     w_idx_raw;
    logic [IW-1:0]   w_idx_clip;
    logic [IW-1:0]   w_idx;
    logic [IW-1:0]   r_idx;
    logic            r_neg_a;
    logic            r_neg_b;
    logic [SINE_W-1:0] r_mag;

    assign w_prod     = PW'(i_phase[29:0]) * PW'(SINE_TABLE_DEPTH);
    assign w_idx_raw  = w_prod[PW-1:30];
    assign w_idx_clip = (w_idx_raw >= DEPTH_W) ? TOP_IDX : w_idx_raw[IW-1:0];
    assign w_idx      = i_phase[30] ? (TOP_IDX - w_idx_clip) : w_idx_clip;

    always_ff @(posedge i_clk) begin
        r_idx   <= w_idx;
        r_neg_a <= i_phase[31];
        r_mag   <= w_rom[r_idx];
        r_neg_b <= r_neg_a;
    end

    assign o_look.neg = r_neg_b;
    assign o_look.mag = r_mag;

endmodule

>>> sv/etbg_serial_mult.sv
module etbg_serial_mult #(
    parameter int A_W = 31,
    parameter int B_W = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_busy,
    output logic [A_W+B_W-1:0] o_product
);
    import etbg_pkg::*;

    localparam int CW = $clog2(B_W + 1);

    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      n_cnt;
    logic [A_W-1:0]     r_a;
    logic [A_W+B_W-1:0] r_p;
    logic [A_W+B_W-1:0] n_p;
    logic [A_W:0]       w_sum;

    // one multiplier bit per cycle, lsb first, product shifts right
    assign w_sum = {1'b0, r_p[A_W+B_W-1:B_W]} + {1'b0, r_a};

    always_comb begin
        n_cnt = r_cnt;
        n_p   = r_p;
        if (i_start) begin
            n_cnt = CW'(B_W);
            n_p   = {{A_W{1'b0}}, i_b};
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (r_p[0]) begin
                n_p = {w_sum, r_p[B_W-1:1]};
            end else begin
                n_p = {1'b0, r_p[A_W+B_W-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
        if (i_start) begin
            r_a <= i_a;
        end
    end

    assign o_busy    = (r_cnt != '0);
    assign o_product = r_p;

endmodule

>>> sv/enveloped_tone_burst_generator_top.sv
// channel | direction | handshake                  | payload
// input   | in        | i_in_valid / o_in_stall    | i_restart
// output  | out       | o_out_valid / i_out_stall  | o_sample, o_last, o_active
// config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// a burst sample passes from word to word through the two reads of the registered
// sine rom, two passes (load plus 16 steps) through the bit-serial shift-add
// multiplier, the load of the output register and the return to idle; an idle
// result goes from idle straight to the output load; one word is in flight at
// a time; a stalled output word holds back the output load
// synchronous active-low reset clears state, config, phases and burst state
// the next word is taken while a finished word still waits in the output register
module enveloped_tone_burst_generator_top #(
    parameter int SINE_TABLE_DEPTH = etbg_pkg::DEF_SINE_TABLE_DEPTH,
    parameter int SAMPLE_WIDTH     = etbg_pkg::DEF_SAMPLE_WIDTH,
    parameter int LENGTH_WIDTH     = etbg_pkg::DEF_LENGTH_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_restart,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]    o_sample,
    output logic                              o_last,
    output logic                              o_active,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [etbg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [etbg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import etbg_pkg::*;

    localparam int A_W   = SINE_W + GAIN_W;
    localparam int B_W   = GAIN_W;
    localparam int MAG_W = A_W + B_W;
    localparam int SW    = SAMPLE_WIDTH;
    localparam int LW    = LENGTH_WIDTH;
    localparam int RW    = SW + 2;

    localparam logic [MAG_W:0] ROUND_HALF = (MAG_W + 1)'(1) << (45 - SW);
    localparam logic [RW-1:0]  R_MAX_POS  = (RW'(1) << (SW - 1)) - RW'(1);
    localparam logic [RW-1:0]  R_MAX_NEG  = RW'(1) << (SW - 1);
    localparam logic [SW-1:0]  SAT_POS    = {1'b0, {(SW - 1){1'b1}}};
    localparam logic [SW-1:0]  SAT_NEG    = {1'b1, {(SW - 1){1'b0}}};

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LKT  = 3'd1;
    localparam logic [2:0] S_LKE  = 3'd2;
    localparam logic [2:0] S_CAPT = 3'd3;
    localparam logic [2:0] S_CAPE = 3'd4;
    localparam logic [2:0] S_MUL1 = 3'd5;
    localparam logic [2:0] S_MUL2 = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [2:0]         r_state, n_state;
    logic [PHASE_W-1:0] r_phase_step, n_phase_step;
    logic [LW-1:0]      r_burst_length, n_burst_length;
    logic [PHASE_W-1:0] r_envelope_step, n_envelope_step;
    logic [GAIN_W-1:0]  r_gain, n_gain;
    logic [LW-1:0]      r_index, n_index;
    logic [PHASE_W-1:0] r_tone_phase, n_tone_phase;
    logic [PHASE_W-1:0] r_env_phase, n_env_phase;
    logic               r_running, n_running;
    logic [PHASE_W-1:0] r_tph_w, n_tph_w;
    logic [PHASE_W-1:0] r_eph_w, n_eph_w;
    logic               r_act, n_act;
    logic               r_last_w, n_last_w;
    logic [SINE_W-1:0]  r_tone_mag, n_tone_mag;
    logic               r_tone_neg, n_tone_neg;
    logic [SINE_W-1:0]  r_env, n_env;
    logic               r_neg, n_neg;
    logic               r_out_valid, n_out_valid;
    logic [SW-1:0]      r_sample, n_sample;
    logic               r_last, n_last;
    logic               r_active, n_active;

    t_sine_look         w_look;
    logic [PHASE_W-1:0] w_look_phase;
    logic               w_in_acc;
    logic               w_run;
    logic [LW-1:0]      w_idx;
    logic [PHASE_W-1:0] w_tph;
    logic [PHASE_W-1:0] w_eph;
    logic               w_burst;
    logic               w_last;
    logic [GAIN_W-1:0]  w_gabs;
    logic [GAIN_W-1:0]  w_env16;
    logic               w_mul_start;
    logic [A_W-1:0]     w_mul_a;
    logic [B_W-1:0]     w_mul_b;
    logic               w_mul_busy;
    logic [MAG_W-1:0]   w_prod;
    logic [MAG_W:0]     w_round;
    logic [RW-1:0]      w_r;
    logic [SW-1:0]      w_sat;
    logic               w_out_free;

    assign w_look_phase = (r_state == S_LKT) ? r_tph_w : r_eph_w;

    etbg_sine_lookup #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_lookup (
        .i_clk   (i_clk),
        .i_phase (w_look_phase),
        .o_look  (w_look)
    );

    assign w_gabs      = r_gain[GAIN_W-1] ? (~r_gain + 1'b1) : r_gain;
    assign w_mul_start = (r_state == S_CAPE) || ((r_state == S_MUL1) && !w_mul_busy);
    assign w_mul_a     = (r_state == S_CAPE) ? A_W'(r_tone_mag) : w_prod[A_W-1:0];
    assign w_mul_b     = (r_state == S_CAPE) ? w_gabs : {1'b0, r_env};

    etbg_serial_mult #(
        .A_W(A_W),
        .B_W(B_W)
    ) u_mult (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .o_busy    (w_mul_busy),
        .o_product (w_prod)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = (r_state == S_IDLE) && i_in_valid;
    assign w_run      = i_restart | r_running;
    assign w_idx      = i_restart ? '0 : r_index;
    assign w_tph      = i_restart ? '0 : r_tone_phase;
    assign w_eph      = i_restart ? '0 : r_env_phase;
    assign w_burst    = w_run && (r_burst_length != '0);
    assign w_last     = (w_idx >= (r_burst_length - 1'b1));

    assign w_env16 = w_look.neg ? (GAIN_W'(FULL_Q15) + GAIN_W'(w_look.mag))
                                : (GAIN_W'(FULL_Q15) - GAIN_W'(w_look.mag));

    // round half away from zero on the magnitude, then saturate
    assign w_round = {1'b0, w_prod} + ROUND_HALF;
    assign w_r     = w_round[MAG_W:46-SW];

    always_comb begin
        if (r_neg) begin
            w_sat = (w_r > R_MAX_NEG) ? SAT_NEG : SW'(~w_r + 1'b1);
        end else begin
            w_sat = (w_r > R_MAX_POS) ? SAT_POS : w_r[SW-1:0];
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state         = r_state;
        n_phase_step    = r_phase_step;
        n_burst_length  = r_burst_length;
        n_envelope_step = r_envelope_step;
        n_gain          = r_gain;
        n_index         = r_index;
        n_tone_phase    = r_tone_phase;
        n_env_phase     = r_env_phase;
        n_running       = r_running;
        n_tph_w         = r_tph_w;
        n_eph_w         = r_eph_w;
        n_act           = r_act;
        n_last_w        = r_last_w;
        n_tone_mag      = r_tone_mag;
        n_tone_neg      = r_tone_neg;
        n_env           = r_env;
        n_neg           = r_neg;
        n_out_valid     = r_out_valid;
        n_sample        = r_sample;
        n_last          = r_last;
        n_active        = r_active;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PHASE_STEP:    n_phase_step    = i_cfg_data;
                CFG_BURST_LENGTH:  n_burst_length  = i_cfg_data[LW-1:0];
                CFG_ENVELOPE_STEP: n_envelope_step = i_cfg_data;
                CFG_GAIN:          n_gain          = i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_index      = w_idx;
                    n_tone_phase = w_tph;
                    n_env_phase  = w_eph;
                    if (w_burst) begin
                        n_act        = 1'b1;
                        n_last_w     = w_last;
                        n_index      = w_idx + 1'b1;
                        n_tone_phase = w_tph + r_phase_step;
                        n_env_phase  = w_eph + r_envelope_step;
                        n_running    = !w_last;
                        n_tph_w      = w_tph;
                        n_eph_w      = w_eph + QUARTER_TURN;
                        n_state      = S_LKT;
                    end else begin
                        n_act     = 1'b0;
                        n_last_w  = 1'b0;
                        n_running = 1'b0;
                        n_state   = S_EMIT;
                    end
                end
            end
            S_LKT: n_state = S_LKE;
            S_LKE: n_state = S_CAPT;
            S_CAPT: begin
                n_tone_mag = w_look.mag;
                n_tone_neg = w_look.neg;
                n_state    = S_CAPE;
            end
            S_CAPE: begin
                n_env   = w_env16[GAIN_W-1:1];
                n_neg   = r_tone_neg ^ r_gain[GAIN_W-1];
                n_state = S_MUL1;
            end
            S_MUL1: begin
                if (!w_mul_busy) begin
                    n_state = S_MUL2;
                end
            end
            S_MUL2: begin
                if (!w_mul_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_sample    = r_act ? w_sat : '0;
                    n_last      = r_act & r_last_w;
                    n_active    = r_act;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_phase_step    <= '0;
            r_burst_length  <= '0;
            r_envelope_step <= '0;
            r_gain          <= '0;
            r_index         <= '0;
            r_tone_phase    <= '0;
            r_env_phase     <= '0;
            r_running       <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_phase_step    <= n_phase_step;
            r_burst_length  <= n_burst_length;
            r_envelope_step <= n_envelope_step;
            r_gain          <= n_gain;
            r_index         <= n_index;
            r_tone_phase    <= n_tone_phase;
            r_env_phase     <= n_env_phase;
            r_running       <= n_running;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tph_w    <= n_tph_w;
        r_eph_w    <= n_eph_w;
        r_act      <= n_act;
        r_last_w   <= n_last_w;
        r_tone_mag <= n_tone_mag;
        r_tone_neg <= n_tone_neg;
        r_env      <= n_env;
        r_neg      <= n_neg;
        r_sample   <= n_sample;
        r_last     <= n_last;
        r_active   <= n_active;
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;
    assign o_last      = r_last;
    assign o_active    = r_active;

    a_idle_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_active) |-> (o_sample == '0) && !o_last)
        else $error("idle word carries a nonzero sample or last flag");

    a_mult_only_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MUL1) || (r_state == S_MUL2)) |-> r_act)
        else $error("multiplier pass without a burst sample");

    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_burst && w_last) |=> !r_running)
        else $error("burst still running after its last sample");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("input not stalled after a word was taken");

endmodule
